>>> src/rcsrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcsrv_pkg;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_SERVO = 2'd1,
    FUNC_MOTOR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_TICK   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SERVO_PERIOD = 2'd0,
    REG_ANGLE_LOW    = 2'd1,
    REG_ANGLE_HIGH   = 2'd2,
    REG_GAS_LIMIT    = 2'd3
  } reg_idx_t;

  localparam logic [7:0]  END_MARK           = 8'h4F;
  localparam logic [7:0]  ANGLE_CEIL         = 8'd180;
  localparam logic [7:0]  ANGLE_RESET        = 8'd90;
  localparam logic [15:0] PULSE_RESET        = 16'd193;
  localparam logic [15:0] SERVO_PERIOD_RESET = 16'd2500;
  localparam logic [7:0]  ANGLE_LOW_RESET    = 8'd5;
  localparam logic [7:0]  ANGLE_HIGH_RESET   = 8'd175;
  localparam logic [7:0]  GAS_LIMIT_RESET    = 8'd120;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         cmd_angle;
    logic signed [15:0] cmd_gas;
    logic [15:0]        cmd_check;
    logic [7:0]         cmd_end;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        servo_out;
    logic        drive_a;
    logic        drive_b;
    logic [15:0] pulse_ticks;
    logic [7:0]  motor_duty;
    logic        motor_running;
  } res_t;

  typedef struct packed {
    logic [15:0] servo_period;
    logic [7:0]  angle_low;
    logic [7:0]  angle_high;
    logic [7:0]  gas_limit;
  } cfg_t;

  // Servo pulse width for each angle, floor((1900*a + 108000) / 1440).
  typedef logic [15:0] ticks_tab_t [0:180];

  function automatic ticks_tab_t build_ticks();
    ticks_tab_t t;
    for (int i = 0; i <= 180; i++) begin
      t[i] = 16'((1900 * i + 108000) / 1440);
    end
    return t;
  endfunction

  localparam ticks_tab_t ANGLE_TICKS = build_ticks();

endpackage

`default_nettype wire

>>> src/rcsrv_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcsrv_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         cmd_angle;
  logic signed [15:0] cmd_gas;
  logic [15:0]        cmd_check;
  logic [7:0]         cmd_end;

  modport source (output valid, func, cmd_angle, cmd_gas, cmd_check, cmd_end,
                  input ready);
  modport sink (input valid, func, cmd_angle, cmd_gas, cmd_check, cmd_end,
                output ready);
endinterface

interface rcsrv_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        servo_out;
  logic        drive_a;
  logic        drive_b;
  logic [15:0] pulse_ticks;
  logic [7:0]  motor_duty;
  logic        motor_running;

  modport source (output valid, status, servo_out, drive_a, drive_b, pulse_ticks,
                  motor_duty, motor_running, input ready);
  modport sink (input valid, status, servo_out, drive_a, drive_b, pulse_ticks,
                motor_duty, motor_running, output ready);
endinterface

interface rcsrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rc_servo_motor_pwm_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Role   | Payload
// cmd     | sink   | func, cmd_angle, cmd_gas, cmd_check, cmd_end
// res     | source | status, servo_out, drive_a, drive_b, pulse_ticks, motor_duty,
//         |        | motor_running
// cfg     | sink   | index, data (always ready)
//
// One transaction is taken every clock unless a stalled result blocks it.
// Each gives one result via the input register, update logic and result register.
// A stalled result holds in the result register while the input register still
// takes one more transaction, after which cmd.ready follows res.ready.
// Synchronous reset restores config, valid flags and core state to power-up values.

module rc_servo_motor_pwm_controller_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  rcsrv_cmd_if.sink   cmd,
  rcsrv_res_if.source res,
  rcsrv_cfg_if.sink   cfg
);

  rcsrv_pkg::cfg_t cfg_regs;
  rcsrv_pkg::cmd_t stage_data;
  logic            stage_valid;
  logic            core_take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.servo_period <= rcsrv_pkg::SERVO_PERIOD_RESET;
      cfg_regs.angle_low    <= rcsrv_pkg::ANGLE_LOW_RESET;
      cfg_regs.angle_high   <= rcsrv_pkg::ANGLE_HIGH_RESET;
      cfg_regs.gas_limit    <= rcsrv_pkg::GAS_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (rcsrv_pkg::reg_idx_t'(cfg.index))
        rcsrv_pkg::REG_SERVO_PERIOD: cfg_regs.servo_period <= cfg.data;
        rcsrv_pkg::REG_ANGLE_LOW:    cfg_regs.angle_low    <= cfg.data[7:0];
        rcsrv_pkg::REG_ANGLE_HIGH:   cfg_regs.angle_high   <= cfg.data[7:0];
        rcsrv_pkg::REG_GAS_LIMIT:    cfg_regs.gas_limit    <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  rcsrv_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .take  (core_take),
    .data  (stage_data),
    .valid (stage_valid)
  );

  rcsrv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .in_valid (stage_valid),
    .in_data  (stage_data),
    .take     (core_take),
    .res      (res)
  );

endmodule

`default_nettype wire

>>> src/rcsrv_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsrv_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  rcsrv_cmd_if.sink         cmd,
  input  wire logic         take,
  output rcsrv_pkg::cmd_t   data,
  output logic              valid
);

  // The register refills in the same cycle that the core takes its item.
  assign cmd.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      data.func      <= cmd.func;
      data.cmd_angle <= cmd.cmd_angle;
      data.cmd_gas   <= cmd.cmd_gas;
      data.cmd_check <= cmd.cmd_check;
      data.cmd_end   <= cmd.cmd_end;
    end
  end

endmodule

`default_nettype wire

>>> src/rcsrv_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsrv_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  rcsrv_pkg::cfg_t       cfg,
  input  wire logic             in_valid,
  input  rcsrv_pkg::cmd_t       in_data,
  output logic                  take,
  rcsrv_res_if.source           res
);

  logic [15:0] servo_count, servo_count_next;
  logic [15:0] pulse_width, pulse_width_next;
  logic        servo_level, servo_level_next;
  logic [7:0]  motor_count, motor_count_next;
  logic [7:0]  duty_value, duty_value_next;
  logic        backward, backward_next;
  logic        motor_enabled, motor_enabled_next;
  logic        leg_a, leg_a_next;
  logic        leg_b, leg_b_next;
  logic [7:0]  stored_angle, stored_angle_next;
  logic [15:0] stored_gas, stored_gas_next;

  logic                 out_valid;
  rcsrv_pkg::res_t      out_data, out_data_next;
  rcsrv_pkg::status_t   status;

  logic                 frame_ok;
  logic [7:0]           angle_clamped;
  logic [7:0]           angle_idx;
  logic signed [16:0]   gas_wide;
  logic signed [16:0]   lim_pos;
  logic signed [16:0]   lim_neg;
  logic signed [16:0]   gas_clamped;
  logic signed [16:0]   gas_abs;
  logic [15:0]          servo_inc;
  logic [7:0]           motor_inc;

  assign take = !out_valid || res.ready;

  always_comb begin
    frame_ok = (in_data.cmd_end == rcsrv_pkg::END_MARK) &&
               ((in_data.cmd_gas ^ {8'd0, in_data.cmd_angle}) == in_data.cmd_check);

    angle_clamped = in_data.cmd_angle;
    if (angle_clamped < cfg.angle_low) begin
      angle_clamped = cfg.angle_low;
    end
    if (angle_clamped > cfg.angle_high) begin
      angle_clamped = cfg.angle_high;
    end
    angle_idx = (angle_clamped > rcsrv_pkg::ANGLE_CEIL) ? rcsrv_pkg::ANGLE_CEIL
                                                        : angle_clamped;

    gas_wide = {in_data.cmd_gas[15], in_data.cmd_gas};
    lim_pos  = {9'd0, cfg.gas_limit};
    lim_neg  = -lim_pos;
    if (gas_wide < lim_neg) begin
      gas_clamped = lim_neg;
    end else if (gas_wide > lim_pos) begin
      gas_clamped = lim_pos;
    end else begin
      gas_clamped = gas_wide;
    end
    gas_abs = gas_clamped[16] ? -gas_clamped : gas_clamped;

    servo_inc = servo_count + 16'd1;
    motor_inc = motor_count + 8'd1;
  end

  always_comb begin
    servo_count_next   = servo_count;
    pulse_width_next   = pulse_width;
    servo_level_next   = servo_level;
    motor_count_next   = motor_count;
    duty_value_next    = duty_value;
    backward_next      = backward;
    motor_enabled_next = motor_enabled;
    leg_a_next         = leg_a;
    leg_b_next         = leg_b;
    stored_angle_next  = stored_angle;
    stored_gas_next    = stored_gas;
    status             = rcsrv_pkg::STATUS_TICK;

    case (in_data.func)
      rcsrv_pkg::FUNC_FRAME: begin
        if (!frame_ok) begin
          status = rcsrv_pkg::STATUS_REJECT;
        end else begin
          status = rcsrv_pkg::STATUS_OK;
          if (stored_angle != in_data.cmd_angle) begin
            stored_angle_next = angle_clamped;
            pulse_width_next  = rcsrv_pkg::ANGLE_TICKS[angle_idx];
          end
          if (in_data.cmd_gas == 16'sd0) begin
            motor_enabled_next = 1'b0;
          end else begin
            motor_enabled_next = 1'b1;
            if (stored_gas != in_data.cmd_gas) begin
              stored_gas_next = gas_clamped[15:0];
              backward_next   = gas_clamped[16];
              duty_value_next = gas_abs[7:0];
            end
          end
        end
      end
      rcsrv_pkg::FUNC_SERVO: begin
        servo_count_next = servo_inc;
        if (servo_inc == pulse_width) begin
          servo_level_next = 1'b0;
        end
        // The period match wins over the pulse match.
        if (servo_inc == cfg.servo_period) begin
          servo_level_next = 1'b1;
          servo_count_next = 16'd0;
        end
      end
      rcsrv_pkg::FUNC_MOTOR: begin
        if (motor_enabled) begin
          motor_count_next = motor_inc;
          if (motor_inc == duty_value) begin
            leg_a_next = 1'b0;
            leg_b_next = 1'b0;
          end
          if (motor_inc == 8'd0) begin
            if (backward) begin
              leg_b_next = 1'b1;
            end else begin
              leg_a_next = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    out_data_next.status        = status;
    out_data_next.servo_out     = servo_level_next;
    out_data_next.drive_a       = leg_a_next;
    out_data_next.drive_b       = leg_b_next;
    out_data_next.pulse_ticks   = pulse_width_next;
    out_data_next.motor_duty    = duty_value_next;
    out_data_next.motor_running = motor_enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_count   <= 16'd0;
      pulse_width   <= rcsrv_pkg::PULSE_RESET;
      servo_level   <= 1'b0;
      motor_count   <= 8'd0;
      duty_value    <= 8'd0;
      backward      <= 1'b0;
      motor_enabled <= 1'b0;
      leg_a         <= 1'b0;
      leg_b         <= 1'b0;
      stored_angle  <= rcsrv_pkg::ANGLE_RESET;
      stored_gas    <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= in_valid;
      end
      if (take && in_valid) begin
        servo_count   <= servo_count_next;
        pulse_width   <= pulse_width_next;
        servo_level   <= servo_level_next;
        motor_count   <= motor_count_next;
        duty_value    <= duty_value_next;
        backward      <= backward_next;
        motor_enabled <= motor_enabled_next;
        leg_a         <= leg_a_next;
        leg_b         <= leg_b_next;
        stored_angle  <= stored_angle_next;
        stored_gas    <= stored_gas_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      out_data <= out_data_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_data.status;
  assign res.servo_out     = out_data.servo_out;
  assign res.drive_a       = out_data.drive_a;
  assign res.drive_b       = out_data.drive_b;
  assign res.pulse_ticks   = out_data.pulse_ticks;
  assign res.motor_duty    = out_data.motor_duty;
  assign res.motor_running = out_data.motor_running;

endmodule

`default_nettype wire

>>> src/rcsrv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsrv_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic [1:0]  res_status,
  input  wire logic        res_servo_out,
  input  wire logic [15:0] res_pulse_ticks,
  input  wire logic [7:0]  res_motor_duty,
  input  wire logic        res_motor_running
);

  logic        have_prev;
  logic [15:0] prev_pulse;
  logic [7:0]  prev_duty;
  logic        prev_running;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (res_valid && res_ready) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      prev_pulse   <= res_pulse_ticks;
      prev_duty    <= res_motor_duty;
      prev_running <= res_motor_running;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) &&
      $stable(res_pulse_ticks) && $stable(res_motor_duty) && $stable(res_servo_out))
    else $error("stalled result changed");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_pulse_ticks >= 16'd75 && res_pulse_ticks <= 16'd312)
    else $error("servo pulse width out of range");

  // Only an accepted frame may change the pulse width, duty or motor state.
  a_non_frame_keeps: assert property (@(posedge clk) disable iff (rst)
    res_valid && have_prev && res_status != rcsrv_pkg::STATUS_OK |->
      res_pulse_ticks == prev_pulse && res_motor_duty == prev_duty &&
      res_motor_running == prev_running)
    else $error("motor or servo settings changed without an accepted frame");

endmodule

bind rc_servo_motor_pwm_controller_unit rcsrv_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_status        (res.status),
  .res_servo_out     (res.servo_out),
  .res_pulse_ticks   (res.pulse_ticks),
  .res_motor_duty    (res.motor_duty),
  .res_motor_running (res.motor_running)
);

`default_nettype wire

>>> verif/tb_rc_servo_motor_pwm_controller_unit.sv
`timescale 1ns / 1ps

module tb_rc_servo_motor_pwm_controller_unit;

  localparam int IDLE_PCT = 38;
  // The package names no selector for the unused code.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk;
  logic rst;

  rcsrv_cmd_if cmd_if ();
  rcsrv_res_if res_if ();
  rcsrv_cfg_if cfg_if ();

  rc_servo_motor_pwm_controller_unit u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  // Controller state as the block should hold it.
  logic [15:0] servo_per;
  logic [7:0]  ang_lo;
  logic [7:0]  ang_hi;
  logic [7:0]  gas_lim;
  logic [15:0] srv_cnt;
  logic [15:0] srv_width;
  logic        srv_level;
  logic [7:0]  mtr_cnt;
  logic [7:0]  mtr_duty;
  logic        mtr_rev;
  logic        mtr_on;
  logic        leg_fwd;
  logic        leg_rev;
  logic [7:0]  last_angle;
  logic [15:0] last_gas;

  rcsrv_pkg::cmd_t cmd_feed[$];
  rcsrv_pkg::res_t readouts[$];
  int   fed_count;
  int   taken_count;
  int   fail_count;
  logic cmd_took;
  logic steady;

  logic [7:0]  sent_angle;
  logic [15:0] sent_gas;

  task automatic restore_controller();
    servo_per  = rcsrv_pkg::SERVO_PERIOD_RESET;
    ang_lo     = rcsrv_pkg::ANGLE_LOW_RESET;
    ang_hi     = rcsrv_pkg::ANGLE_HIGH_RESET;
    gas_lim    = rcsrv_pkg::GAS_LIMIT_RESET;
    srv_cnt    = '0;
    srv_width  = rcsrv_pkg::PULSE_RESET;
    srv_level  = 1'b0;
    mtr_cnt    = '0;
    mtr_duty   = '0;
    mtr_rev    = 1'b0;
    mtr_on     = 1'b0;
    leg_fwd    = 1'b0;
    leg_rev    = 1'b0;
    last_angle = rcsrv_pkg::ANGLE_RESET;
    last_gas   = '0;
  endtask

  task automatic load_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      rcsrv_pkg::REG_SERVO_PERIOD: servo_per = val;
      rcsrv_pkg::REG_ANGLE_LOW:    ang_lo = val[7:0];
      rcsrv_pkg::REG_ANGLE_HIGH:   ang_hi = val[7:0];
      rcsrv_pkg::REG_GAS_LIMIT:    gas_lim = val[7:0];
      default: ;
    endcase
  endtask

  function automatic rcsrv_pkg::res_t controller_step(rcsrv_pkg::cmd_t c);
    rcsrv_pkg::res_t r;
    logic [7:0]  ang;
    logic [15:0] gas;
    int          s;
    int          lim;
    r = '0;
    r.status = rcsrv_pkg::STATUS_TICK;
    case (c.func)
      rcsrv_pkg::FUNC_FRAME: begin
        gas = c.cmd_gas;
        if (c.cmd_end != rcsrv_pkg::END_MARK ||
            (gas ^ {8'h00, c.cmd_angle}) != c.cmd_check) begin
          r.status = rcsrv_pkg::STATUS_REJECT;
        end else begin
          r.status = rcsrv_pkg::STATUS_OK;
          if (c.cmd_angle != last_angle) begin
            // Low bound first, then high bound, even when the bounds cross.
            ang = c.cmd_angle;
            if (ang < ang_lo) ang = ang_lo;
            if (ang > ang_hi) ang = ang_hi;
            last_angle = ang;
            if (ang > rcsrv_pkg::ANGLE_CEIL) ang = rcsrv_pkg::ANGLE_CEIL;
            srv_width = 16'((1900 * int'(ang) + 108000) / 1440);
          end
          if (gas == 16'h0000) begin
            mtr_on = 1'b0;
          end else begin
            mtr_on = 1'b1;
            if (gas != last_gas) begin
              s = int'($signed(gas));
              lim = int'(gas_lim);
              if (s < -lim) s = -lim;
              if (s > lim) s = lim;
              last_gas = s[15:0];
              mtr_rev = s < 0;
              mtr_duty = (s < 0) ? 8'(-s) : 8'(s);
            end
          end
        end
      end
      rcsrv_pkg::FUNC_SERVO: begin
        srv_cnt = srv_cnt + 16'd1;
        if (srv_cnt == srv_width) srv_level = 1'b0;
        if (srv_cnt == servo_per) begin
          srv_level = 1'b1;
          srv_cnt = '0;
        end
      end
      rcsrv_pkg::FUNC_MOTOR: begin
        if (mtr_on) begin
          mtr_cnt = mtr_cnt + 8'd1;
          if (mtr_cnt == mtr_duty) begin
            leg_fwd = 1'b0;
            leg_rev = 1'b0;
          end
          // On wrap only one leg is set; the other keeps its level.
          if (mtr_cnt == 8'd0) begin
            if (mtr_rev) leg_rev = 1'b1;
            else leg_fwd = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.servo_out     = srv_level;
    r.drive_a       = leg_fwd;
    r.drive_b       = leg_rev;
    r.pulse_ticks   = srv_width;
    r.motor_duty    = mtr_duty;
    r.motor_running = mtr_on;
    return r;
  endfunction

  function automatic rcsrv_pkg::cmd_t good_frame(logic [7:0] a, logic [15:0] g);
    rcsrv_pkg::cmd_t c;
    c.func      = rcsrv_pkg::FUNC_FRAME;
    c.cmd_angle = a;
    c.cmd_gas   = g;
    c.cmd_check = g ^ {8'h00, a};
    c.cmd_end   = rcsrv_pkg::END_MARK;
    sent_angle  = a;
    sent_gas    = g;
    return c;
  endfunction

  function automatic rcsrv_pkg::cmd_t random_frame();
    rcsrv_pkg::cmd_t c;
    logic [7:0]  a;
    logic [15:0] g;
    int          roll;
    int          small_gas;
    roll = $urandom_range(9);
    if (roll < 2) a = sent_angle;
    else if (roll == 2) a = 8'($urandom_range(255));
    else a = 8'($urandom_range(180));
    roll = $urandom_range(19);
    small_gas = int'($urandom_range(600));
    small_gas = small_gas - 300;
    if (roll == 0) g = '0;
    else if (roll < 5) g = sent_gas;
    else if (roll < 9) g = 16'($urandom);
    else g = 16'(small_gas);
    c = good_frame(a, g);
    if ($urandom_range(99) < 15) begin
      roll = $urandom_range(2);
      if (roll != 1) begin
        c.cmd_end = 8'($urandom);
        if (c.cmd_end == rcsrv_pkg::END_MARK) c.cmd_end = ~rcsrv_pkg::END_MARK;
      end
      if (roll != 0) c.cmd_check = c.cmd_check ^ 16'($urandom_range(65535, 1));
    end
    return c;
  endfunction

  function automatic rcsrv_pkg::cmd_t random_item(int pct_frame, int pct_servo);
    rcsrv_pkg::cmd_t c;
    int   pick;
    c.func      = rcsrv_pkg::FUNC_MOTOR;
    c.cmd_angle = 8'($urandom);
    c.cmd_gas   = 16'($urandom);
    c.cmd_check = 16'($urandom);
    c.cmd_end   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) c.func = FUNC_SPARE;
    else if (pick < 3 + pct_frame) c = random_frame();
    else if (pick < 3 + pct_frame + pct_servo) c.func = rcsrv_pkg::FUNC_SERVO;
    return c;
  endfunction

  task automatic feed(rcsrv_pkg::cmd_t c);
    cmd_feed.push_back(c);
    fed_count++;
  endtask

  task automatic feed_random(int n, int pct_frame, int pct_servo);
    for (int i = 0; i < n; i++) feed(random_item(pct_frame, pct_servo));
  endtask

  task automatic feed_tick(logic [1:0] f, int n);
    rcsrv_pkg::cmd_t c;
    c = '0;
    c.func = f;
    for (int i = 0; i < n; i++) feed(c);
  endtask

  task automatic write_reg(rcsrv_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every transaction has been taken and answered.
  task automatic drain();
    while (taken_count != fed_count || readouts.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic match_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Bookkeeping at the accepting edge: register writes and command transactions.
  always @(posedge clk) begin
    if (rst) begin
      restore_controller();
      cmd_took <= 1'b0;
    end else begin
      cmd_took <= cmd_if.valid && cmd_if.ready;
      if (cfg_if.valid && cfg_if.ready) load_register(cfg_if.index, cfg_if.data);
      if (cmd_if.valid && cmd_if.ready) begin
        readouts.push_back(controller_step({cmd_if.func, cmd_if.cmd_angle, cmd_if.cmd_gas,
                                            cmd_if.cmd_check, cmd_if.cmd_end}));
        taken_count++;
      end
    end
  end

  always @(negedge clk) begin : drive_cmd
    rcsrv_pkg::cmd_t nxt;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_took) begin
      if (cmd_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = cmd_feed.pop_front();
        cmd_if.func      <= nxt.func;
        cmd_if.cmd_angle <= nxt.cmd_angle;
        cmd_if.cmd_gas   <= nxt.cmd_gas;
        cmd_if.cmd_check <= nxt.cmd_check;
        cmd_if.cmd_end   <= nxt.cmd_end;
        cmd_if.valid     <= 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_if.ready <= !rst && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watch_res
    rcsrv_pkg::res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (readouts.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want = readouts.pop_front();
        match_field("status", int'(want.status), int'(res_if.status));
        match_field("servo_out", int'(want.servo_out), int'(res_if.servo_out));
        match_field("drive_a", int'(want.drive_a), int'(res_if.drive_a));
        match_field("drive_b", int'(want.drive_b), int'(res_if.drive_b));
        match_field("pulse_ticks", int'(want.pulse_ticks), int'(res_if.pulse_ticks));
        match_field("motor_duty", int'(want.motor_duty), int'(res_if.motor_duty));
        match_field("motor_running", int'(want.motor_running),
                    int'(res_if.motor_running));
      end
    end
  end

  initial begin : stimulus
    rcsrv_pkg::cmd_t c;
    rst              = 1'b1;
    steady           = 1'b0;
    fed_count        = 0;
    taken_count      = 0;
    fail_count       = 0;
    sent_angle       = rcsrv_pkg::ANGLE_RESET;
    sent_gas         = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.func      = rcsrv_pkg::FUNC_FRAME;
    cmd_if.cmd_angle = '0;
    cmd_if.cmd_gas   = '0;
    cmd_if.cmd_check = '0;
    cmd_if.cmd_end   = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = rcsrv_pkg::REG_SERVO_PERIOD;
    cfg_if.data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the power-up settings.
    feed(good_frame(8'd90, 16'h0000));    // same angle, gas zero stops the motor
    feed_tick(rcsrv_pkg::FUNC_MOTOR, 1);  // ignored while stopped
    feed(good_frame(8'd0, 16'h7FFF));     // clamped up to the low bound, gas to the limit
    feed_tick(rcsrv_pkg::FUNC_MOTOR, 2);
    feed(good_frame(8'd255, 16'h8000));   // clamped down, full negative gas
    feed(good_frame(8'd180, 16'hFFFF));   // clamps back onto the stored angle
    feed(good_frame(8'd120, 16'd120));    // gas exactly at the limit
    feed(good_frame(8'd175, -16'sd121));  // just beyond the negative limit
    c = good_frame(8'd60, 16'd5);
    c.cmd_end = 8'h4E;
    feed(c);                              // wrong terminator
    c = good_frame(8'd60, 16'd5);
    c.cmd_check = c.cmd_check ^ 16'h8001;
    feed(c);                              // wrong checksum
    c = good_frame(8'd200, 16'd1);
    c.cmd_end = ~rcsrv_pkg::END_MARK;
    c.cmd_check = ~c.cmd_check;
    feed(c);                              // both wrong
    c = '1;
    c.func = FUNC_SPARE;
    feed(c);                              // unused selector
    feed_tick(rcsrv_pkg::FUNC_SERVO, 3);
    feed(good_frame(8'd5, 16'h5555));
    feed(good_frame(8'd5, 16'h5555));     // repeated frame changes nothing
    feed_tick(rcsrv_pkg::FUNC_MOTOR, 2);
    feed(good_frame(8'd90, 16'h0000));
    feed_random(100, 25, 35);
    drain();

    write_reg(rcsrv_pkg::REG_SERVO_PERIOD, 16'd1);
    write_reg(rcsrv_pkg::REG_ANGLE_LOW, 16'd0);
    write_reg(rcsrv_pkg::REG_ANGLE_HIGH, 16'd180);
    write_reg(rcsrv_pkg::REG_GAS_LIMIT, 16'd255);
    feed(good_frame(8'd0, 16'h8000));
    feed(good_frame(8'd180, 16'h7FFF));
    feed(good_frame(8'd181, 16'hFF01));
    feed_random(80, 20, 20);
    drain();

    // No idling on either side in this stretch.
    steady = 1'b1;
    write_reg(rcsrv_pkg::REG_SERVO_PERIOD, 16'd100);
    write_reg(rcsrv_pkg::REG_ANGLE_LOW, 16'd0);
    write_reg(rcsrv_pkg::REG_ANGLE_HIGH, 16'd40);
    write_reg(rcsrv_pkg::REG_GAS_LIMIT, 16'd10);
    feed_random(160, 20, 55);
    drain();
    steady = 1'b0;

    // Crossed angle bounds and a zero gas limit.
    write_reg(rcsrv_pkg::REG_SERVO_PERIOD, 16'hFFFF);
    write_reg(rcsrv_pkg::REG_ANGLE_LOW, 16'd180);
    write_reg(rcsrv_pkg::REG_ANGLE_HIGH, 16'd0);
    write_reg(rcsrv_pkg::REG_GAS_LIMIT, 16'd0);
    feed_random(80, 30, 30);
    drain();

    write_reg(rcsrv_pkg::REG_SERVO_PERIOD, 16'($urandom_range(150, 80)));
    write_reg(rcsrv_pkg::REG_ANGLE_LOW, 16'($urandom_range(60)));
    write_reg(rcsrv_pkg::REG_ANGLE_HIGH, 16'($urandom_range(180, 100)));
    write_reg(rcsrv_pkg::REG_GAS_LIMIT, 16'($urandom_range(255)));
    feed_random(300, 15, 35);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
